// ===== rtl/pwl_src_pkg.sv =====
// Shared types and constants of the piecewise-linear source evaluator.
package pwl_src_pkg;

	localparam int DEF_MAX_POINTS  = 8;
	localparam int DEF_TIME_WIDTH  = 32;
	localparam int DEF_LEVEL_WIDTH = 32;

	localparam int ENTRY_W  = 3;
	localparam int COUNT_W  = 4;
	localparam int REGION_W = 2;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	typedef enum logic [REGION_W-1:0] {
		REGION_FIRST = 2'd0,
		REGION_MID   = 2'd1,
		REGION_LAST  = 2'd2
	} region_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SPAN,
		ST_OFF,
		ST_MAG,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/pwl_src_in_if.sv =====
// Input channel: breakpoint writes and evaluate requests.
interface pwl_src_in_if
	import pwl_src_pkg::*;
#(
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
	parameter int LEVEL_WIDTH = DEF_LEVEL_WIDTH
) ();
	logic                   valid;
	logic                   ready;
	op_t                    op;
	logic [ENTRY_W-1:0]     entry_index;
	logic [TIME_WIDTH-1:0]  time_value;
	logic [LEVEL_WIDTH-1:0] level_value;

	modport source (output valid, output op, output entry_index, output time_value,
		output level_value, input ready);
	modport sink (input valid, input op, input entry_index, input time_value,
		input level_value, output ready);
endinterface

// ===== rtl/pwl_src_out_if.sv =====
// Output channel: evaluated level and region.
interface pwl_src_out_if
	import pwl_src_pkg::*;
#(
	parameter int LEVEL_WIDTH = DEF_LEVEL_WIDTH
) ();
	logic                   valid;
	logic                   ready;
	logic [LEVEL_WIDTH-1:0] level_out;
	logic [REGION_W-1:0]    region;

	modport source (output valid, output level_out, output region, input ready);
	modport sink (input valid, input level_out, input region, output ready);
endinterface

// ===== rtl/pwl_src_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pwl_src_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/piecewise_linear_source_eval_top.sv =====
// Top level of the piecewise-linear source evaluator.
//
//   channel    direction  handshake        payload
//   item       in         valid / ready    op, entry_index, time_value, level_value
//   result     out        valid / ready    level_out, region
//   cfg        in         cfg_we           cfg_wdata (points_in_use)
//
// A write transfer stores the breakpoint in the table RAM.
// An evaluate scans the n entries in use through the RAM read port, one a cycle,
// and ST_DECIDE then picks a clamped or exact answer or goes on to interpolate.
// Interpolation reuses one add/subtract unit for a shift-add multiply and a
// restoring divide.
// Reset clears the control state only; the table holds nothing useful until written.
// A finished result waits in the output register while a new item is taken.
module piecewise_linear_source_eval_top
	import pwl_src_pkg::*;
#(
	parameter int MAX_POINTS  = DEF_MAX_POINTS,
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
	parameter int LEVEL_WIDTH = DEF_LEVEL_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	pwl_src_in_if.sink         item,
	pwl_src_out_if.source      result
);
	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int EW = TIME_WIDTH + LEVEL_WIDTH;
	localparam int PW = TIME_WIDTH + LEVEL_WIDTH;
	localparam int AW = ((TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH) + 1;
	localparam int SW = $clog2(AW);

	state_t state_q, state_d;

	logic [COUNT_W-1:0]     pts_q;
	logic [CW-1:0]          cnt_q, n_q, n_eval;
	logic                   rd_vld_q, first_q;
	logic [TIME_WIDTH-1:0]  query_q;
	logic [TIME_WIDTH-1:0]  tmin_q, tmax_q, tlo_q, thi_q, span_q;
	logic [LEVEL_WIDTH-1:0] lmin_q, lmax_q, lex_q, llo_q, lhi_q, mag_q;
	logic                   exact_q, have_lo_q, have_hi_q, rising_q;
	logic [PW-1:0]          prod_q;
	logic [SW-1:0]          step_q;
	logic [LEVEL_WIDTH-1:0] res_level_q, out_level_q;
	region_t                res_region_q, out_region_q;
	logic                   out_vld_q;

	logic                   accept, scan_issue, load_out, slot_ok, ram_we;
	logic [EW-1:0]          rd_data;
	logic [TIME_WIDTH-1:0]  rd_time;
	logic [LEVEL_WIDTH-1:0] rd_level;

	logic [AW-1:0]          alu_a, alu_b;
	logic                   alu_sub;
	logic [AW:0]            alu_sum;
	logic                   alu_carry;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign slot_ok    = int'(item.entry_index) < MAX_POINTS;
	assign ram_we     = accept && (item.op == OP_WRITE) && slot_ok;

	pwl_src_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(IW'(item.entry_index)),
		.wdata({item.time_value, item.level_value}),
		.raddr(cnt_q[IW-1:0]),
		.rdata(rd_data)
	);

	assign rd_time  = rd_data[EW-1:LEVEL_WIDTH];
	assign rd_level = rd_data[LEVEL_WIDTH-1:0];

	always_comb begin
		if (pts_q == '0) begin
			n_eval = CW'(1);
		end else if (int'(pts_q) > MAX_POINTS) begin
			n_eval = CW'(MAX_POINTS);
		end else begin
			n_eval = CW'(pts_q);
		end
	end

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_SPAN: begin
				alu_a   = AW'(thi_q);
				alu_b   = AW'(tlo_q);
				alu_sub = 1'b1;
			end
			ST_OFF: begin
				alu_a   = AW'(query_q);
				alu_b   = AW'(tlo_q);
				alu_sub = 1'b1;
			end
			ST_MAG: begin
				alu_a   = rising_q ? AW'(lhi_q) : AW'(llo_q);
				alu_b   = rising_q ? AW'(llo_q) : AW'(lhi_q);
				alu_sub = 1'b1;
			end
			ST_MUL: begin
				alu_a   = AW'(prod_q[PW-1:TIME_WIDTH]);
				alu_b   = prod_q[0] ? AW'(mag_q) : '0;
			end
			ST_DIV: begin
				alu_a   = AW'({prod_q[PW-1:LEVEL_WIDTH], prod_q[LEVEL_WIDTH-1]});
				alu_b   = AW'(span_q);
				alu_sub = 1'b1;
			end
			ST_FIN: begin
				alu_a   = AW'(llo_q);
				alu_b   = AW'(prod_q[LEVEL_WIDTH-1:0]);
				alu_sub = !rising_q;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW + 1)'(alu_sub);
	assign alu_carry = alu_sum[AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		scan_issue = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (item.op == OP_EVAL)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_issue = (cnt_q < n_q);
				if (!scan_issue && !rd_vld_q) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if ((query_q <= tmin_q) || (query_q >= tmax_q) || exact_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN: state_d = ST_OFF;
			ST_OFF:  state_d = ST_MAG;
			ST_MAG:  state_d = ST_MUL;
			ST_MUL: begin
				if (step_q == '0) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_vld_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q     <= COUNT_W'(1);
			out_vld_q <= 1'b0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				pts_q <= cfg_wdata;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			rd_vld_q <= scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (item.op == OP_EVAL)) begin
			query_q   <= item.time_value;
			n_q       <= n_eval;
			cnt_q     <= '0;
			first_q   <= 1'b1;
			exact_q   <= 1'b0;
			have_lo_q <= 1'b0;
			have_hi_q <= 1'b0;
		end
		if (scan_issue) begin
			cnt_q <= cnt_q + CW'(1);
		end
		if (rd_vld_q) begin
			first_q <= 1'b0;
			if (first_q || (rd_time < tmin_q)) begin
				tmin_q <= rd_time;
				lmin_q <= rd_level;
			end
			if (first_q || (rd_time > tmax_q)) begin
				tmax_q <= rd_time;
				lmax_q <= rd_level;
			end
			if ((rd_time == query_q) && !exact_q) begin
				exact_q <= 1'b1;
				lex_q   <= rd_level;
			end
			if ((rd_time < query_q) && (!have_lo_q || (rd_time > tlo_q))) begin
				have_lo_q <= 1'b1;
				tlo_q     <= rd_time;
				llo_q     <= rd_level;
			end
			if ((rd_time > query_q) && (!have_hi_q || (rd_time < thi_q))) begin
				have_hi_q <= 1'b1;
				thi_q     <= rd_time;
				lhi_q     <= rd_level;
			end
		end

		case (state_q)
			ST_DECIDE: begin
				if (query_q <= tmin_q) begin
					res_level_q  <= lmin_q;
					res_region_q <= REGION_FIRST;
				end else if (query_q >= tmax_q) begin
					res_level_q  <= lmax_q;
					res_region_q <= REGION_LAST;
				end else begin
					res_level_q  <= lex_q;
					res_region_q <= REGION_MID;
				end
			end
			ST_SPAN: begin
				span_q   <= alu_sum[TIME_WIDTH-1:0];
				rising_q <= $signed(lhi_q) >= $signed(llo_q);
			end
			ST_OFF: begin
				prod_q <= PW'(alu_sum[TIME_WIDTH-1:0]);
			end
			ST_MAG: begin
				mag_q  <= alu_sum[LEVEL_WIDTH-1:0];
				step_q <= SW'(TIME_WIDTH - 1);
			end
			ST_MUL: begin
				prod_q <= {alu_sum[LEVEL_WIDTH:0], prod_q[TIME_WIDTH-1:1]};
				if (step_q == '0) begin
					step_q <= SW'(LEVEL_WIDTH - 1);
				end else begin
					step_q <= step_q - SW'(1);
				end
			end
			ST_DIV: begin
				prod_q <= {(alu_carry ? alu_sum[TIME_WIDTH-1:0] : alu_a[TIME_WIDTH-1:0]),
					prod_q[LEVEL_WIDTH-2:0], alu_carry};
				step_q <= step_q - SW'(1);
			end
			ST_FIN: begin
				res_level_q  <= alu_sum[LEVEL_WIDTH-1:0];
				res_region_q <= REGION_MID;
			end
			default: begin
			end
		endcase

		if (load_out) begin
			out_level_q  <= res_level_q;
			out_region_q <= res_region_q;
		end
	end

	assign result.valid     = out_vld_q;
	assign result.level_out = out_level_q;
	assign result.region    = out_region_q;
endmodule
